>>> rtl/core/i2cts_pkg.sv
package i2cts_pkg;

  localparam int unsigned CountBitsDefault = 16;

  localparam logic [7:0] AddrMask = 8'hfe;
  localparam logic [7:0] ReadBit  = 8'h01;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_DONE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_READ      = 2'd1,
    KIND_REG_WRITE = 2'd2,
    KIND_REG_READ  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_NO_DEVICE = 2'd1,
    ST_DATA_NACK = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_ADDR  = 8'b0000_0010,
    PH_REG   = 8'b0000_0100,
    PH_RADDR = 8'b0000_1000,
    PH_WAITB = 8'b0001_0000,
    PH_WDATA = 8'b0010_0000,
    PH_RDATA = 8'b0100_0000,
    PH_STOP  = 8'b1000_0000
  } phase_e;

  // input request, registered at the slave side
  typedef struct packed {
    logic [7:0]  engine_byte;
    logic        ack_missing;
    logic [7:0]  write_byte;
    logic [15:0] byte_count;
    logic [7:0]  reg_address;
    logic [7:0]  dev_address;
    logic [1:0]  kind;
  } req_t;

  // result request, first member in the highest bits
  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_byte;
    logic [7:0] cmd_byte;
    logic       cmd_nack;
    logic       cmd_read;
    logic       cmd_write;
    logic       cmd_stop;
    logic       cmd_start;
    logic       cmd_valid;
  } res_t;

endpackage

>>> rtl/core/i2c_transaction_sequencer.sv
// i2c transaction sequencer
// drives a byte-level i2c master for plain write, plain read, register write
// and register read (the latter turns the bus round with a repeated start)
// slave channel: one request per beat; tuser selects begin, next write byte
// or engine completion, tdata carries the request fields
// master channel: exactly one result per accepted request, possibly all zero;
// it holds a byte command for the engine, a write byte request, a received
// byte and the final status
// a request is registered in the input stage, processed by the combinational
// next-phase logic, and its result is registered in the output stage
// throughput: one request per cycle while the output register is not stalled
// stall: while the output register holds an untaken result, processing
// halts; an empty input stage still fills, then s_axis_tready_o drops
// reset: phase returns to idle, counters and status clear, both stages empty
// a nack on the address or a data byte issues a stop; done follows once the
// engine reports that stop complete
module i2c_transaction_sequencer #(
  parameter int unsigned COUNT_BITS = i2cts_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[1:0], dev_address[9:2], reg_address[17:10], byte_count[33:18],
  // write_byte[41:34], ack_missing[42], engine_byte[50:43], zeros above
  input  logic [55:0] s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cmd_valid[0], cmd_start[1], cmd_stop[2], cmd_write[3], cmd_read[4],
  // cmd_nack[5], cmd_byte[13:6], need_byte[14], read_valid[15],
  // read_byte[23:16], done_res[24], status[26:25], zeros above
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned ResW = $bits(i2cts_pkg::res_t);

  // input stage
  logic                in_v_q;
  i2cts_pkg::req_t     in_q;
  i2cts_pkg::action_e  act_q;

  // output stage
  logic                out_v_q;
  i2cts_pkg::res_t     res_q;
  i2cts_pkg::res_t     res_d;

  // transaction state
  i2cts_pkg::phase_e   phase_q, phase_d;
  logic [1:0]          kind_q, kind_d;
  logic [7:0]          dev_q, dev_d;
  logic [7:0]          reg_q, reg_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic [1:0]          pend_q, pend_d;

  logic                out_free;
  logic                step;
  logic                in_take;
  logic [COUNT_BITS+15:0] cnt_ext;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  left_dec;
  logic                   last;

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign step            = in_v_q && out_free;
  assign s_axis_tready_o = !in_v_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // count cut to the counter width, zero treated as one
  assign cnt_ext  = {{COUNT_BITS{1'b0}}, in_q.byte_count};
  assign cnt      = cnt_ext[COUNT_BITS-1:0];
  assign left_dec = left_q - COUNT_BITS'(1);
  assign last     = (left_q == COUNT_BITS'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q  <= i2cts_pkg::req_t'(s_axis_tdata_i[50:0]);
      act_q <= i2cts_pkg::action_e'(s_axis_tuser_i);
    end
  end

  always_comb begin
    res_d  = '0;
    phase_d = phase_q;
    kind_d = kind_q;
    dev_d  = dev_q;
    reg_d  = reg_q;
    left_d = left_q;
    pend_d = pend_q;
    case (act_q)
      i2cts_pkg::ACT_BEGIN: begin
        if (phase_q == i2cts_pkg::PH_IDLE) begin
          kind_d = in_q.kind;
          dev_d  = in_q.dev_address & i2cts_pkg::AddrMask;
          reg_d  = in_q.reg_address;
          left_d = (cnt == '0) ? COUNT_BITS'(1) : cnt;
          pend_d = i2cts_pkg::ST_SUCCESS;
          res_d.cmd_valid = 1'b1;
          res_d.cmd_start = 1'b1;
          res_d.cmd_write = 1'b1;
          res_d.cmd_byte  = dev_d |
            ((in_q.kind == i2cts_pkg::KIND_READ) ? i2cts_pkg::ReadBit : 8'h00);
          phase_d = i2cts_pkg::PH_ADDR;
        end
      end
      i2cts_pkg::ACT_BYTE: begin
        if (phase_q == i2cts_pkg::PH_WAITB) begin
          res_d.cmd_valid = 1'b1;
          res_d.cmd_stop  = last;
          res_d.cmd_write = 1'b1;
          res_d.cmd_byte  = in_q.write_byte;
          phase_d = i2cts_pkg::PH_WDATA;
        end
      end
      i2cts_pkg::ACT_DONE: begin
        unique case (phase_q)
          i2cts_pkg::PH_ADDR: begin
            if (in_q.ack_missing) begin
              pend_d = i2cts_pkg::ST_NO_DEVICE;
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = 1'b1;
              phase_d = i2cts_pkg::PH_STOP;
            end else if (kind_q == i2cts_pkg::KIND_WRITE) begin
              res_d.need_byte = 1'b1;
              phase_d = i2cts_pkg::PH_WAITB;
            end else if (kind_q == i2cts_pkg::KIND_READ) begin
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = last;
              res_d.cmd_read  = 1'b1;
              res_d.cmd_nack  = last;
              phase_d = i2cts_pkg::PH_RDATA;
            end else begin
              res_d.cmd_valid = 1'b1;
              res_d.cmd_write = 1'b1;
              res_d.cmd_byte  = reg_q;
              phase_d = i2cts_pkg::PH_REG;
            end
          end
          i2cts_pkg::PH_REG: begin
            if (in_q.ack_missing) begin
              pend_d = i2cts_pkg::ST_DATA_NACK;
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = 1'b1;
              phase_d = i2cts_pkg::PH_STOP;
            end else if (kind_q == i2cts_pkg::KIND_REG_WRITE) begin
              res_d.need_byte = 1'b1;
              phase_d = i2cts_pkg::PH_WAITB;
            end else begin
              res_d.cmd_valid = 1'b1;
              res_d.cmd_start = 1'b1;
              res_d.cmd_write = 1'b1;
              res_d.cmd_byte  = dev_q | i2cts_pkg::ReadBit;
              phase_d = i2cts_pkg::PH_RADDR;
            end
          end
          i2cts_pkg::PH_RADDR: begin
            if (in_q.ack_missing) begin
              pend_d = i2cts_pkg::ST_NO_DEVICE;
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = 1'b1;
              phase_d = i2cts_pkg::PH_STOP;
            end else begin
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = last;
              res_d.cmd_read  = 1'b1;
              res_d.cmd_nack  = last;
              phase_d = i2cts_pkg::PH_RDATA;
            end
          end
          i2cts_pkg::PH_WDATA: begin
            if (in_q.ack_missing) begin
              pend_d = i2cts_pkg::ST_DATA_NACK;
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = 1'b1;
              phase_d = i2cts_pkg::PH_STOP;
            end else begin
              left_d = left_dec;
              if (last) begin
                res_d.done_res = 1'b1;
                res_d.status   = i2cts_pkg::ST_SUCCESS;
                phase_d = i2cts_pkg::PH_IDLE;
              end else begin
                res_d.need_byte = 1'b1;
                phase_d = i2cts_pkg::PH_WAITB;
              end
            end
          end
          i2cts_pkg::PH_RDATA: begin
            // slave never nacks read data, ack_missing is ignored here
            res_d.read_valid = 1'b1;
            res_d.read_byte  = in_q.engine_byte;
            left_d = left_dec;
            if (last) begin
              res_d.done_res = 1'b1;
              res_d.status   = i2cts_pkg::ST_SUCCESS;
              phase_d = i2cts_pkg::PH_IDLE;
            end else begin
              res_d.cmd_valid = 1'b1;
              res_d.cmd_stop  = (left_dec == COUNT_BITS'(1));
              res_d.cmd_read  = 1'b1;
              res_d.cmd_nack  = (left_dec == COUNT_BITS'(1));
              phase_d = i2cts_pkg::PH_RDATA;
            end
          end
          i2cts_pkg::PH_STOP: begin
            res_d.done_res = 1'b1;
            res_d.status   = pend_q;
            phase_d = i2cts_pkg::PH_IDLE;
          end
          default: begin
            // idle or waiting for a write byte: completion ignored
          end
        endcase
      end
      default: begin
        // unused request kind gives an all-zero result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cts_pkg::PH_IDLE;
      kind_q  <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      left_q  <= '0;
      pend_q  <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(32 - ResW){1'b0}}, res_q};

  // a write byte is only requested with bytes still to send
  a_waitb_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2cts_pkg::PH_WAITB |-> left_q != '0)
    else $error("waiting for a write byte with no bytes left");

  // a done result leaves the sequencer idle until it is taken
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.done_res |-> phase_q == i2cts_pkg::PH_IDLE)
    else $error("done reported while a transaction is still running");

  // status only travels with done
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_q.done_res |-> res_q.status == i2cts_pkg::ST_SUCCESS)
    else $error("status set without done");

  // state holds while the output stage is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready_i |=> $stable(phase_q) && $stable(left_q))
    else $error("state moved while the result was stalled");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

endmodule

>>> bench/i2cts_bench_pkg.sv
package i2cts_bench_pkg;

  import i2cts_pkg::*;

  // tracks the sequencer state and holds the results still owed by the block
  class transfer_scoreboard;

    phase_e      phase;
    kind_e       kind_q;
    logic [7:0]  dev_q;
    logic [7:0]  reg_q;
    logic [15:0] left_q;
    status_e     pend_q;
    res_t        owed_results[$];
    int unsigned mismatches;

    function new();
      phase      = PH_IDLE;
      kind_q     = KIND_WRITE;
      dev_q      = '0;
      reg_q      = '0;
      left_q     = '0;
      pend_q     = ST_SUCCESS;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function res_t command(bit sta, bit sto, bit wr, bit rd, bit nk, logic [7:0] b);
      res_t r;
      r           = '0;
      r.cmd_valid = 1'b1;
      r.cmd_start = sta;
      r.cmd_stop  = sto;
      r.cmd_write = wr;
      r.cmd_read  = rd;
      r.cmd_nack  = nk;
      r.cmd_byte  = wr ? b : 8'h00;
      return r;
    endfunction

    // nack seen: stop goes out, status is held until the stop completes
    function res_t abort_with_stop(status_e code);
      pend_q = code;
      phase  = PH_STOP;
      return command(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    endfunction

    function res_t ask_write_byte();
      res_t r;
      r           = '0;
      r.need_byte = 1'b1;
      phase       = PH_WAITB;
      return r;
    endfunction

    // last read byte is nacked by the master and closed with a stop
    function res_t read_next();
      bit last;
      last  = (left_q == 16'd1);
      phase = PH_RDATA;
      return command(1'b0, last, 1'b0, 1'b1, last, 8'h00);
    endfunction

    function res_t report_done(status_e code);
      res_t r;
      r          = '0;
      r.done_res = 1'b1;
      r.status   = code;
      phase      = PH_IDLE;
      return r;
    endfunction

    function res_t next_result(action_e act, req_t q);
      res_t r;
      r = '0;
      case (act)
        ACT_BEGIN: begin
          if (phase == PH_IDLE) begin
            kind_q = kind_e'(q.kind);
            dev_q  = q.dev_address & AddrMask;
            reg_q  = q.reg_address;
            left_q = (q.byte_count == 16'd0) ? 16'd1 : q.byte_count;
            pend_q = ST_SUCCESS;
            r      = command(1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                             dev_q | ((kind_q == KIND_READ) ? ReadBit : 8'h00));
            phase  = PH_ADDR;
          end
        end
        ACT_BYTE: begin
          if (phase == PH_WAITB) begin
            r     = command(1'b0, left_q == 16'd1, 1'b1, 1'b0, 1'b0, q.write_byte);
            phase = PH_WDATA;
          end
        end
        ACT_DONE: begin
          case (phase)
            PH_ADDR: begin
              if (q.ack_missing) r = abort_with_stop(ST_NO_DEVICE);
              else if (kind_q == KIND_WRITE) r = ask_write_byte();
              else if (kind_q == KIND_READ) r = read_next();
              else begin
                r     = command(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, reg_q);
                phase = PH_REG;
              end
            end
            PH_REG: begin
              if (q.ack_missing) r = abort_with_stop(ST_DATA_NACK);
              else if (kind_q == KIND_REG_WRITE) r = ask_write_byte();
              else begin
                r     = command(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, dev_q | ReadBit);
                phase = PH_RADDR;
              end
            end
            PH_RADDR: begin
              if (q.ack_missing) r = abort_with_stop(ST_NO_DEVICE);
              else r = read_next();
            end
            PH_WDATA: begin
              if (q.ack_missing) r = abort_with_stop(ST_DATA_NACK);
              else begin
                left_q = left_q - 16'd1;
                if (left_q == 16'd0) r = report_done(ST_SUCCESS);
                else r = ask_write_byte();
              end
            end
            PH_RDATA: begin
              // ack_missing means nothing while reading data
              left_q = left_q - 16'd1;
              if (left_q == 16'd0) r = report_done(ST_SUCCESS);
              else r = read_next();
              r.read_valid = 1'b1;
              r.read_byte  = q.engine_byte;
            end
            PH_STOP: r = report_done(pend_q);
            default: ;
          endcase
        end
        default: ;
      endcase
      return r;
    endfunction

    // every accepted request owes one result; returns whether it did anything
    function bit note_request(action_e act, req_t q);
      res_t r;
      r = next_result(act, q);
      owed_results.push_back(r);
      return r != '0;
    endfunction

    function string describe(logic [31:0] word);
      res_t r;
      r = word[26:0];
      return $sformatf({"cmd v%0b sta%0b sto%0b wr%0b rd%0b nack%0b byte %02h ",
                        "need %0b read v%0b %02h done %0b status %0d pad %02h"},
                       r.cmd_valid, r.cmd_start, r.cmd_stop, r.cmd_write, r.cmd_read,
                       r.cmd_nack, r.cmd_byte, r.need_byte, r.read_valid, r.read_byte,
                       r.done_res, r.status, word[31:27]);
    endfunction

    function void log_mismatch(string what, string want_txt, logic [31:0] word);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %s, got %s", what, want_txt, describe(word));
    endfunction

    function void check_result(logic [31:0] word);
      res_t got;
      res_t want;
      bit   bad;
      got = word[26:0];
      if (owed_results.size() == 0) begin
        log_mismatch("result with no request behind it", "nothing", word);
        return;
      end
      want = owed_results.pop_front();
      bad = (word[31:27] !== 5'd0) ||
            (got.cmd_valid !== want.cmd_valid) || (got.cmd_start !== want.cmd_start) ||
            (got.cmd_stop !== want.cmd_stop) || (got.cmd_write !== want.cmd_write) ||
            (got.cmd_read !== want.cmd_read) || (got.cmd_nack !== want.cmd_nack) ||
            (got.cmd_byte !== want.cmd_byte) || (got.need_byte !== want.need_byte) ||
            (got.read_valid !== want.read_valid) || (got.read_byte !== want.read_byte) ||
            (got.done_res !== want.done_res) || (got.status !== want.status);
      if (bad) log_mismatch("result mismatch", describe({5'd0, want}), word);
    endfunction

  endclass

endpackage

>>> bench/tb_i2c_transaction_sequencer.sv
module tb_i2c_transaction_sequencer;

  timeunit 1ns;
  timeprecision 1ps;

  import i2cts_pkg::*;
  import i2cts_bench_pkg::*;

  localparam int unsigned QuietLimit = 5000;  // cycles with no handshake at all
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned PhaseQuota = 315;   // requests that do something, per phase

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  int unsigned idle_pct      = 0;  // chance the host leaves a cycle empty
  int unsigned stall_pct     = 0;  // chance the result side is not ready
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;
  int unsigned quiet_cycles  = 0;

  transfer_scoreboard sb;

  i2c_transaction_sequencer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // result side: random stalls, plus a long hold-off whenever one is asked for
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready_i <= 1'b0;
      end else if (holds_granted != holds_asked) begin
        holds_granted = holds_asked;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // every result taken is checked against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // watchdog: the run is stuck if neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offers one request, with random idle cycles ahead of it, and waits for it
  // to be taken; the predictor only moves here so the next pick sees its state
  task automatic send_request(input action_e act, input req_t q, output bit useful);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {5'd0, q};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    useful = sb.note_request(act, q);
  endtask

  task automatic send_fields(action_e act, kind_e k, logic [7:0] dev, logic [7:0] rg,
                             logic [15:0] cnt, logic [7:0] wb, logic nk, logic [7:0] eb);
    req_t q;
    bit   useful;
    q.kind        = k;
    q.dev_address = dev;
    q.reg_address = rg;
    q.byte_count  = cnt;
    q.write_byte  = wb;
    q.ack_missing = nk;
    q.engine_byte = eb;
    send_request(act, q, useful);
  endtask

  // host pauses until every owed result has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // acts as host and byte engine: mostly what the sequencer is waiting for,
  // with random content, and a share of noise that may be ignored or out of turn
  task automatic pick_request(output action_e act, output req_t q);
    int unsigned roll;
    bit          big;
    q.kind        = kind_e'($urandom_range(3));
    q.dev_address = 8'($urandom);
    q.reg_address = 8'($urandom);
    q.write_byte  = 8'($urandom);
    q.engine_byte = 8'($urandom);
    q.ack_missing = ($urandom_range(99) < 8);
    roll = $urandom_range(99);
    if (roll < 4) q.byte_count = 16'd0;
    else if (roll < 14) q.byte_count = 16'($urandom);
    else if (roll < 20) q.byte_count = 16'($urandom_range(16, 5));
    else q.byte_count = 16'($urandom_range(4, 1));
    if ($urandom_range(99) < 8) begin
      act = action_e'($urandom_range(3));
      q.ack_missing = 1'($urandom_range(1));
    end else begin
      case (sb.phase)
        PH_IDLE:  act = ACT_BEGIN;
        PH_WAITB: act = ACT_BYTE;
        default: begin
          act = ACT_DONE;
          if (sb.phase == PH_RDATA || sb.phase == PH_STOP)
            q.ack_missing = 1'($urandom_range(1));
        end
      endcase
    end
    // long transfers are cut short by a nack before any data phase runs long
    big = (sb.left_q > 16'd16);
    if (act == ACT_DONE && big) begin
      if (sb.phase == PH_RADDR || sb.phase == PH_WDATA ||
          (sb.phase == PH_ADDR && sb.kind_q == KIND_READ)) q.ack_missing = 1'b1;
      else if (sb.phase == PH_ADDR || sb.phase == PH_REG)
        q.ack_missing = 1'($urandom_range(1));
    end
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned count;
    action_e     act;
    req_t        q;
    bit          useful;
    count = 0;
    while (count < quota) begin
      pick_request(act, q);
      send_request(act, q, useful);
      if (useful) count++;
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // requests with nothing to act on
    send_fields(ACT_DONE, KIND_REG_READ, 8'hff, 8'hff, 16'hffff, 8'hff, 1'b1, 8'hff);
    send_fields(ACT_NONE, KIND_REG_READ, 8'hff, 8'hff, 16'hffff, 8'hff, 1'b1, 8'hff);
    send_fields(ACT_BYTE, KIND_WRITE, 8'h00, 8'h00, 16'h0000, 8'hff, 1'b0, 8'h00);
    // one-byte write: begin while busy, completion while awaiting the byte,
    // then a nack on the final byte, which already carried a stop
    send_fields(ACT_BEGIN, KIND_WRITE, 8'hff, 8'hff, 16'd1, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_BEGIN, KIND_READ, 8'h00, 8'h00, 16'd3, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_BYTE, KIND_WRITE, 8'h00, 8'h00, 16'd0, 8'hff, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b1, 8'h00);
    send_fields(ACT_DONE, KIND_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    // register read with a zero count, slave nack flag ignored on the data byte
    send_fields(ACT_BEGIN, KIND_REG_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b1, 8'ha5);
    // full-size read with no device answering
    send_fields(ACT_BEGIN, KIND_READ, 8'h55, 8'h00, 16'hffff, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b1, 8'h00);
    send_fields(ACT_DONE, KIND_READ, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    // register write nacked on the register byte
    send_fields(ACT_BEGIN, KIND_REG_WRITE, 8'haa, 8'h5a, 16'd2, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    send_fields(ACT_DONE, KIND_REG_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b1, 8'h00);
    send_fields(ACT_DONE, KIND_REG_WRITE, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0, 8'h00);
    drain();

    // no idling; halfway the result side holds off while requests keep coming
    run_random(PhaseQuota / 2);
    holds_asked++;
    run_random(PhaseQuota - PhaseQuota / 2);
    drain();

    idle_pct = 57;
    run_random(PhaseQuota);
    drain();

    idle_pct  = 0;
    stall_pct = 57;
    run_random(PhaseQuota);
    drain();

    idle_pct  = 6;
    stall_pct = 6;
    run_random(PhaseQuota);
    drain();

    // run on with the host quiet so a stray extra result would still be caught
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/i2cts_pkg.sv
rtl/core/i2c_transaction_sequencer.sv
bench/i2cts_bench_pkg.sv
bench/tb_i2c_transaction_sequencer.sv
